### hw/rtl/svd_pkg.sv
// shared types, constants and helpers for the sliding-window viterbi decoder
`timescale 1ns / 1ps
package svd_pkg;

  localparam int NumStates    = 64;
  localparam int WindowLength = 96;
  localparam int FlushDepth   = 96;
  localparam int MetricWidth  = 16;
  localparam int RingDepth    = WindowLength + FlushDepth;
  localparam int RingAw       = $clog2(RingDepth);
  localparam int WinAw        = $clog2(WindowLength);
  localparam int WinBytes     = WindowLength / 8;
  localparam int StageW       = 19;
  localparam int QueueDepth   = 4;
  localparam int QueueAw      = $clog2(QueueDepth);

  localparam logic [MetricWidth-1:0] MetricInit = MetricWidth'(16'h7FFF);

  typedef logic [MetricWidth-1:0] metric_t;

  // queue entry from the byte intake to the trellis engine
  typedef struct packed {
    logic [7:0]  data;
    logic        first;
    logic        rate;
    logic [14:0] nbytes;
  } cmd_t;

  // received symbol for one stage: value and erasure flag
  typedef struct packed {
    logic erased;
    logic val;
  } sym_t;

  function automatic logic parity6(input logic [5:0] v);
    return ^v;
  endfunction

endpackage

### hw/rtl/svd_front.sv
// byte intake: latches frame settings on the first byte and queues coded bytes
`timescale 1ns / 1ps
module svd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [14:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          coded_byte,
  output logic                q_valid,
  input  logic                q_ready,
  output svd_pkg::cmd_t       q_cmd
);
  import svd_pkg::*;

  localparam logic CfgRate  = 1'b0;
  localparam logic CfgBytes = 1'b1;

  logic              code_rate;
  logic [14:0]       frame_bytes;
  logic              lat_rate;
  logic [14:0]       lat_bytes;
  logic [15:0]       taken;
  logic [15:0]       ncoded;
  logic              in_frame;
  logic [14:0]       eff_bytes;
  logic              rate_use;
  logic [14:0]       bytes_use;
  logic [18:0]       nbits;
  logic [19:0]       n3;

  cmd_t              q_mem [QueueDepth];
  logic [QueueAw-1:0] wr_ptr;
  logic [QueueAw-1:0] rd_ptr;
  logic [QueueAw:0]   count;
  logic              push;
  logic              pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      code_rate   <= 1'b0;
      frame_bytes <= 15'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgRate:  code_rate   <= cfg_data[0];
        CfgBytes: frame_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  assign eff_bytes = (frame_bytes == 15'd0) ? 15'd1 : frame_bytes;
  assign rate_use  = in_frame ? lat_rate : code_rate;
  assign bytes_use = in_frame ? lat_bytes : eff_bytes;
  assign nbits     = {bytes_use, 3'b000} + 19'd0;
  assign n3        = {1'b0, nbits} + {2'b00, nbits[18:1]};
  // coded bytes per frame
  always_comb begin
    if (rate_use) ncoded = 16'(({1'b0, n3} + 21'd7) >> 3);
    else          ncoded = 16'({1'b0, nbits} >> 2);
  end

  assign push     = in_valid && in_ready;
  assign in_ready = (count != (QueueAw+1)'(QueueDepth));
  assign pop      = q_valid && q_ready;
  assign q_valid  = (count != '0);
  assign q_cmd    = q_mem[rd_ptr];

  // frame tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame  <= 1'b0;
      taken     <= '0;
      lat_rate  <= 1'b0;
      lat_bytes <= 15'd1;
    end else if (push) begin
      if (!in_frame) begin
        lat_rate  <= code_rate;
        lat_bytes <= eff_bytes;
      end
      if (taken + 16'd1 >= ncoded) begin
        in_frame <= 1'b0;
        taken    <= '0;
      end else begin
        in_frame <= 1'b1;
        taken    <= taken + 16'd1;
      end
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= '{data: coded_byte, first: !in_frame,
                         rate: rate_use, nbytes: bytes_use};
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QueueAw+1)'(push) - (QueueAw+1)'(pop);
    end
  end

endmodule

### hw/rtl/svd_back.sv
// trellis engine: acs per stage, decision ring, traceback and byte output
`timescale 1ns / 1ps
module svd_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_ready,
  input  svd_pkg::cmd_t q_cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    decoded_byte,
  output logic          frame_last
);
  import svd_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_STEP  = 3'd1;
  localparam logic [2:0] S_BEST  = 3'd2;
  localparam logic [2:0] S_TRACE = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;
  localparam logic [2:0] S_RDW   = 3'd5;

  logic [2:0]         st;
  metric_t            pm [NumStates];
  metric_t            pm_next [NumStates];
  logic [63:0]        dec_word;
  logic [63:0]        ring [RingDepth];
  logic [63:0]        ring_q;
  logic [RingAw-1:0]  rd_addr;
  logic [RingAw-1:0]  wr_addr;
  logic [RingAw-1:0]  fwd_addr;
  logic [StageW-1:0]  stage;
  logic [WinAw-1:0]   wcnt;
  logic [7:0]         held;
  logic [3:0]         left;
  logic               pend_v;
  logic               pend_b;
  logic               rate;
  logic [14:0]        nbytes;
  logic [15:0]        taken;
  logic [WindowLength-1:0] wbits;

  logic [StageW-1:0]  nbits;
  logic [StageW-1:0]  total;
  logic [StageW-1:0]  padded;
  logic [15:0]        ncoded;
  logic [19:0]        n3;
  logic [15:0]        nb_up;
  logic [13:0]        nq4;
  logic [31:0]        nwin_prod;
  logic [11:0]        nwin;

  sym_t               r0, r1;
  logic               can_step;
  logic               do_pend;
  logic [3:0]         left_after;

  logic [5:0]         best;
  logic [6:0]         bidx;
  logic [5:0]         tstate;
  logic [7:0]         tk;
  logic [StageW-1:0]  fwd;
  logic [StageW-1:0]  wstart;
  logic [4:0]         ebyte;
  logic               emit_ok;

  // frame geometry
  assign nbits  = StageW'({nbytes, 3'b000});
  assign n3     = 20'(nbits) + 20'(nbits[StageW-1:1]);
  assign ncoded = rate ? 16'((n3 + 20'd7) >> 3) : 16'(nbits >> 2);
  // windows per frame: ceil(nbytes / 12), the divide by 3 as a reciprocal multiply
  assign nb_up     = {1'b0, nbytes} + 16'd11;
  assign nq4       = nb_up[15:2];
  assign nwin_prod = 32'(nq4) * 32'd43691;
  assign nwin      = nwin_prod[28:17];
  assign padded    = StageW'({nwin, 6'b000000}) + StageW'({nwin, 5'b00000});
  assign total     = padded + StageW'(FlushDepth);

  // symbol extraction for the current stage
  always_comb begin
    r0 = '{erased: 1'b1, val: 1'b0};
    r1 = '{erased: 1'b1, val: 1'b0};
    can_step   = 1'b1;
    do_pend    = 1'b0;
    left_after = left;
    if (stage < nbits) begin
      if (pend_v) begin
        r0 = '{erased: 1'b0, val: pend_b};
      end else if (left != 4'd0) begin
        left_after = left - 4'd1;
        r0 = '{erased: 1'b0, val: held[3'(left_after)]};
      end else begin
        can_step = 1'b0;
      end
      if (can_step && (!rate || !stage[0])) begin
        if (left_after == 4'd0) begin
          do_pend  = 1'b1;
          can_step = 1'b0;
        end else begin
          left_after = left_after - 4'd1;
          r1 = '{erased: 1'b0, val: held[3'(left_after)]};
        end
      end
    end
  end

  // 64 add-compare-select units
  always_comb begin
    logic [5:0]  p0;
    logic        g0, g1, bm0s;
    logic [1:0]  bm0, bm1, act;
    metric_t     c0, c1;
    act = 2'(!r0.erased) + 2'(!r1.erased);
    for (int s = 0; s < NumStates; s++) begin
      p0 = {s[4:0], 1'b0};
      g0 = s[5] ^ parity6(p0 & 6'h1B);
      g1 = s[5] ^ parity6(p0 & 6'h39);
      bm0s = 1'b0;
      bm0 = 2'(!r0.erased && (r0.val ^ g0)) + 2'(!r1.erased && (r1.val ^ g1));
      bm1 = act - bm0;
      c0 = pm[p0] + metric_t'(bm0);
      c1 = pm[p0 | 6'd1] + metric_t'(bm1);
      if (c0 <= c1) begin
        pm_next[s] = c0;
        dec_word[s] = bm0s;
      end else begin
        pm_next[s] = c1;
        dec_word[s] = 1'b1;
      end
    end
  end

  assign q_ready   = (st == S_IDLE);
  assign wstart    = fwd + StageW'(1) - StageW'(FlushDepth + WindowLength);
  assign emit_ok   = (32'(wstart) + 32'(ebyte) * 8 < 32'(nbits));
  assign out_valid = (st == S_EMIT) && emit_ok;
  assign decoded_byte = wbits[WindowLength-1 - 8*ebyte -: 8];
  assign frame_last = (32'(wstart) + 32'(ebyte) * 8 + 8 >= 32'(nbits));

  // decision ring
  always_ff @(posedge clk) begin
    if (st == S_STEP && can_step) ring[wr_addr] <= dec_word;
    ring_q <= ring[rd_addr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st      <= S_IDLE;
      stage   <= '0;
      wcnt    <= '0;
      left    <= '0;
      pend_v  <= 1'b0;
      taken   <= '0;
      rate    <= 1'b0;
      nbytes  <= 15'd1;
      wr_addr <= '0;
    end else begin
      unique case (st)
        S_IDLE: begin
          if (q_valid) begin
            held <= q_cmd.data;
            left <= 4'd8;
            if (q_cmd.first) begin
              rate    <= q_cmd.rate;
              nbytes  <= q_cmd.nbytes;
              taken   <= 16'd1;
              stage   <= '0;
              wcnt    <= '0;
              pend_v  <= 1'b0;
              wr_addr <= '0;
              for (int s = 0; s < NumStates; s++) pm[s] <= (s == 0) ? '0 : MetricInit;
            end else begin
              taken <= taken + 16'd1;
            end
            st <= S_STEP;
          end
        end
        S_STEP: begin
          if (stage >= total) begin
            if (taken >= ncoded) begin
              stage   <= '0;
              pend_v  <= 1'b0;
              left    <= '0;
              wr_addr <= '0;
            end
            st <= S_IDLE;
          end else if (do_pend) begin
            pend_v <= 1'b1;
            pend_b <= r0.val;
            left   <= '0;
            st     <= S_IDLE;
          end else if (!can_step) begin
            st <= S_IDLE;
          end else begin
            for (int s = 0; s < NumStates; s++) pm[s] <= pm_next[s];
            pend_v   <= 1'b0;
            left     <= left_after;
            fwd      <= stage;
            fwd_addr <= wr_addr;
            wr_addr  <= (wr_addr == RingAw'(RingDepth - 1)) ? '0 : wr_addr + 1'b1;
            stage    <= stage + 1'b1;
            wcnt     <= (wcnt == WinAw'(WindowLength - 1)) ? '0 : wcnt + 1'b1;
            if (wcnt == WinAw'(WindowLength - 1) &&
                stage >= StageW'(FlushDepth + WindowLength - 1) &&
                (stage + StageW'(1) - StageW'(FlushDepth + WindowLength)) < nbits) begin
              best <= '0;
              bidx <= 7'd1;
              st   <= S_BEST;
            end
          end
        end
        // best-metric search, one state a cycle
        S_BEST: begin
          if (bidx == 7'(NumStates)) begin
            tstate  <= best;
            tk      <= '0;
            rd_addr <= fwd_addr;
            st      <= S_RDW;
          end else begin
            if (pm[6'(bidx)] < pm[best]) best <= 6'(bidx);
            bidx <= bidx + 7'd1;
          end
        end
        S_RDW: st <= S_TRACE;
        // traceback, one ring read per step, each after a read-wait state
        S_TRACE: begin
          if (tk >= 8'(FlushDepth)) wbits[WinAw'(tk - 8'(FlushDepth))] <= tstate[5];
          tstate <= {tstate[4:0], ring_q[tstate]};
          if (tk == 8'(RingDepth - 1)) begin
            ebyte <= '0;
            st    <= S_EMIT;
          end else begin
            tk      <= tk + 8'd1;
            rd_addr <= (rd_addr == '0) ? RingAw'(RingDepth - 1) : rd_addr - 1'b1;
            st      <= S_RDW;
          end
        end
        S_EMIT: begin
          if (!emit_ok) begin
            st <= S_STEP;
          end else if (out_ready) begin
            if (ebyte == 5'(WinBytes - 1)) st <= S_STEP;
            else ebyte <= ebyte + 5'd1;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/sliding_window_viterbi_decoder.sv
// top level of the sliding-window viterbi decoder
`timescale 1ns / 1ps
// K=7, 64-state hard-decision viterbi decoder, generators 133/171 octal.
// in channel: coded_byte with in_valid/in_ready, one transfer per coded byte.
// out channel: decoded_byte and frame_last with out_valid/out_ready.
// config: cfg_we, cfg_index (0 code_rate, 1 frame_bytes), cfg_data;
// written between frames, latched by the first coded byte of a frame.
// a four-entry queue separates the byte intake from the trellis engine.
// the engine runs one trellis stage per cycle (4 to 6 per coded byte) when
// not waiting on the queue or busy with a window; it returns to idle to take
// each coded byte from the queue. every 96 stages, once the ring is full, it
// runs the best-state search over all 64 states and a 192-step traceback
// through the decision ring, each step a ring read and a read-wait state;
// then up to 12 decoded bytes of the window leave.
// after the last coded byte the padding and flush stages run on their own.
// reset clears control state; metrics reload at each frame start.
// when the receiver stalls the engine holds; the queue keeps taking bytes
// until it fills.
module sliding_window_viterbi_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [14:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  coded_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  decoded_byte,
  output logic        frame_last
);
  import svd_pkg::*;

  cmd_t q_cmd;
  logic q_valid;
  logic q_ready;

  svd_front u_front (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .coded_byte,
    .q_valid, .q_ready, .q_cmd
  );

  svd_back u_back (
    .clk, .rst, .q_valid, .q_ready, .q_cmd,
    .out_valid, .out_ready, .decoded_byte, .frame_last
  );

endmodule

### tb/sliding_window_viterbi_decoder_tb.sv
// self-checking testbench for the sliding-window viterbi decoder
`timescale 1ns / 1ps
module sliding_window_viterbi_decoder_tb;
  import svd_pkg::*;

  localparam logic RegCodeRate   = 1'b0;
  localparam logic RegFrameBytes = 1'b1;
  localparam int   Erased        = 2;
  localparam int   IdleCycles    = 600;
  localparam int   StallLimit    = 20000;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } dec_byte_t;

  logic        clk, rst;
  logic        cfg_we, cfg_index;
  logic [14:0] cfg_data;
  logic        in_valid, in_ready;
  logic [7:0]  coded_byte;
  logic        out_valid, out_ready;
  logic [7:0]  decoded_byte;
  logic        frame_last;

  sliding_window_viterbi_decoder uut (.*);

  // decoder shadow state
  metric_t      pm[NumStates];
  logic [63:0]  ring[RingDepth];
  int unsigned  stage_idx, win_pos, held, bits_left, taken;
  logic         pend_valid, pend_bit;
  logic         rate_reg, lat_rate;
  int unsigned  len_reg, lat_len;
  logic         trace_bits[WindowLength];

  dec_byte_t    decoded_q[$];
  int           errors = 0;
  int           n_checked = 0, n_sent = 0, n_frames = 0;
  bit           in_idle_en = 0, out_stall_en = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic void load_metrics();
    pm[0] = '0;
    for (int s = 1; s < NumStates; s++) pm[s] = MetricInit;
  endfunction

  function automatic void clear_frame();
    load_metrics();
    stage_idx = 0; win_pos = 0; held = 0; bits_left = 0; taken = 0;
    pend_valid = 0; pend_bit = 0;
  endfunction

  // one add-compare-select stage over all states
  function automatic void acs_stage(int r0, int r1);
    metric_t     nxt[NumStates];
    logic [63:0] word;
    int          active, bm0, bm1;
    logic [5:0]  p0;
    logic        b, g0, g1;
    metric_t     c0, c1;
    word = '0;
    active = (r0 != Erased) + (r1 != Erased);
    for (int sp = 0; sp < NumStates; sp++) begin
      b  = sp[5];
      p0 = 6'((sp & 31) << 1);
      g0 = b ^ (^(p0 & 6'h1B));
      g1 = b ^ (^(p0 & 6'h39));
      bm0 = 0;
      if (r0 != Erased) bm0 += (r0 ^ g0);
      if (r1 != Erased) bm0 += (r1 ^ g1);
      bm1 = active - bm0;
      c0 = metric_t'(pm[p0] + bm0);
      c1 = metric_t'(pm[p0 | 6'd1] + bm1);
      if (c0 <= c1) nxt[sp] = c0;
      else begin
        nxt[sp] = c1;
        word[sp] = 1'b1;
      end
    end
    pm = nxt;
    ring[stage_idx % RingDepth] = word;
  endfunction

  // traceback from the best state and queue the window's decoded bytes
  function automatic void traceback_window();
    int unsigned nbits, first_bit, best, st, ob;
    nbits = lat_len * 8;
    first_bit = stage_idx + 1 - FlushDepth - WindowLength;
    if (first_bit >= nbits) return;
    best = 0;
    for (int k = 1; k < NumStates; k++) if (pm[k] < pm[best]) best = k;
    st = best;
    for (int k = 0; k < FlushDepth; k++)
      st = ((st & 31) << 1) | ring[(stage_idx - k) % RingDepth][st];
    for (int k = 0; k < WindowLength; k++) begin
      trace_bits[WindowLength - 1 - k] = st[5];
      st = ((st & 31) << 1) | ring[(stage_idx - FlushDepth - k) % RingDepth][st];
    end
    for (int wb = 0; wb < WinBytes; wb++) begin
      if (first_bit + wb * 8 >= nbits) continue;
      ob = 0;
      for (int i = 0; i < 8; i++) ob = (ob << 1) | trace_bits[wb * 8 + i];
      decoded_q.push_back('{8'(ob), (first_bit + wb * 8 + 8 >= nbits)});
    end
  endfunction

  function automatic int unsigned coded_len(logic rate, int unsigned nbytes);
    return rate ? (nbytes * 4 * 3 + 7) / 8 : nbytes * 2;
  endfunction

  // advance the trellis on one accepted coded byte
  function automatic void predict_decoded(logic [7:0] b);
    int unsigned nbits, ncoded, total;
    int r0, r1;
    if (taken == 0 && stage_idx == 0 && !pend_valid) begin
      lat_rate = rate_reg;
      lat_len  = len_reg ? len_reg : 1;
      load_metrics();
      win_pos = 0;
    end
    nbits  = lat_len * 8;
    ncoded = coded_len(lat_rate, lat_len);
    total  = ((nbits + WindowLength - 1) / WindowLength) * WindowLength + FlushDepth;
    held = b;
    bits_left = 8;
    taken = (taken + 1) & 16'hFFFF;
    while (stage_idx < total) begin
      r0 = Erased;
      r1 = Erased;
      if (stage_idx < nbits) begin
        if (pend_valid) begin
          r0 = pend_bit;
          pend_valid = 0;
        end else if (bits_left > 0) begin
          bits_left--;
          r0 = (held >> bits_left) & 1;
        end else break;
        if (!lat_rate || !stage_idx[0]) begin
          // g0 bit waits for the next byte when the g1 bit is not here yet
          if (bits_left == 0) begin
            pend_valid = 1;
            pend_bit = r0[0];
            break;
          end
          bits_left--;
          r1 = (held >> bits_left) & 1;
        end
      end
      acs_stage(r0, r1);
      if (win_pos == WindowLength - 1 && stage_idx >= FlushDepth + WindowLength - 1)
        traceback_window();
      win_pos = (win_pos == WindowLength - 1) ? 0 : win_pos + 1;
      stage_idx++;
    end
    if (stage_idx >= total && taken >= ncoded) clear_frame();
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch %0t: %s got %0h want %0h", $time, what, got, want);
  endtask

  // output checker and receiver stalls
  int stall_left = 0;
  always @(posedge clk) begin
    dec_byte_t e;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) report_mismatch("unexpected output", decoded_byte, 0);
        else begin
          e = decoded_q.pop_front();
          n_checked++;
          if (decoded_byte !== e.data) report_mismatch("decoded_byte", decoded_byte, e.data);
          if (frame_last !== e.last) report_mismatch("frame_last", frame_last, e.last);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= (stall_left == 0);
      end else if (out_stall_en && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 9);
        out_ready <= 1'b0;
      end else out_ready <= 1'b1;
    end
  end

  // watchdog on transfer activity
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else if (decoded_q.size() != 0 || in_valid) begin
      quiet <= quiet + 1;
      if (quiet >= StallLimit) begin
        $display("timeout waiting on transfers");
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic send_coded(logic [7:0] v);
    in_valid <= 1'b1;
    coded_byte <= v;
    do @(posedge clk); while (!in_ready);
    predict_decoded(v);
    n_sent++;
    if (in_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (IdleCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [14:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == RegCodeRate) rate_reg = val[0];
    else len_reg = val;
  endtask

  // kind: 0 random, 1 all zeros, 2 all ones
  task automatic run_frame(logic rate, int unsigned nbytes, int kind);
    int unsigned n;
    wait_drained();
    write_reg(RegCodeRate, rate);
    write_reg(RegFrameBytes, 15'(nbytes));
    n = coded_len(rate, nbytes ? nbytes : 1);
    for (int i = 0; i < n; i++)
      send_coded(kind == 1 ? 8'h00 : kind == 2 ? 8'hFF : 8'($urandom));
    n_frames++;
  endtask

  task automatic test_directed();
    write_reg(RegFrameBytes, 15'h7FFF);  // largest length, overwritten before use
    run_frame(1'b0, 1, 1);
    run_frame(1'b0, 1, 2);
    run_frame(1'b1, 1, 2);  // odd length at 2/3: low nibble of last byte unused
    run_frame(1'b1, 2, 0);
    run_frame(1'b0, 0, 0);  // zero length decodes as one byte
    run_frame(1'b1, 0, 1);
    run_frame(1'b1, 3, 0);
  endtask

  task automatic test_random(int unsigned goal);
    int unsigned nb;
    in_idle_en = 1;
    out_stall_en = 1;
    while (n_sent < goal) begin
      nb = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      run_frame(1'($urandom), nb, 0);
    end
  endtask

  task automatic test_backpressure();
    // sender holds off until every decoded byte is out
    run_frame(1'b0, 13, 0);
    wait_drained();
    run_frame(1'b1, 13, 0);
  endtask

  task automatic test_no_idle(int unsigned goal);
    in_idle_en = 0;
    out_stall_en = 0;
    while (n_sent < goal) run_frame(1'($urandom), $urandom_range(1, 10), 0);
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 0; cfg_index = 0; cfg_data = '0;
    in_valid = 0; coded_byte = '0; out_ready = 1'b1;
    rate_reg = 0; len_reg = 1; lat_rate = 0; lat_len = 0;
    clear_frame();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(340);
    test_backpressure();
    test_no_idle(450);
    wait_drained();
    $display("covered %0d frames at both code rates: %0d coded bytes in, %0d decoded out",
             n_frames, n_sent, n_checked);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

### sliding_window_viterbi_decoder.f
hw/rtl/svd_pkg.sv
hw/rtl/svd_front.sv
hw/rtl/svd_back.sv
hw/rtl/sliding_window_viterbi_decoder.sv
tb/sliding_window_viterbi_decoder_tb.sv
